FILE: hw/rtl/ifsh_pkg.sv
// shared types and constants for the indel finder by shifted heads
// no dependencies; used by every module of the block
package ifsh_pkg;

    localparam logic [7:0] CH_UNKNOWN = 8'h58;
    localparam logic [7:0] CH_GAP     = 8'h2D;
    localparam int         POS_W      = 11;
    localparam int         SHIFT_W    = 10;
    localparam int         CMN_W      = 11;

    typedef enum logic [1:0] {
        CMD_MASTER = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_RUN    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DEL     = 2'd0,
        KIND_INS     = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_MIN_RUN   = 2'd0,
        CFG_MAX_SHIFT = 2'd1,
        CFG_VERIFY    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        CALL_INIT,
        CALL_DEL,
        CALL_INS,
        CALL_PLAIN,
        CALL_NONX
    } call_t;

    typedef enum logic [3:0] {
        E_IDLE,
        E_RD,
        E_PR,
        E_POST,
        E_LOOP,
        E_SHIFT,
        E_INSTRY,
        E_DECIDE,
        E_EMIT,
        E_NONX,
        E_CMP,
        E_VER,
        E_SUM
    } eng_state_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] residue;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [10:0] position;
        logic [9:0]  shift_count;
        logic [10:0] common_total;
        logic        verified;
        logic        overflowed;
        logic        truncated;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [3:0] min_run;
        logic [9:0] max_shift;
        logic [6:0] verify_percent;
    } cfg_t;

endpackage

FILE: hw/rtl/indel_finder_by_shifted_heads_core.sv
// load requests (master or query residue) are taken one per cycle while the engine is idle
// a run request scans the stores pair by pair, reading then comparing, for each head search
// and for each shift step, then emits edits and a summary
// all scans go through the single shared scan unit and its registered store reads
// reset clears lengths, overflow flag, queue and output; stores are undefined
// depends on ifsh_pkg, ifsh_front, ifsh_queue, ifsh_engine
module indel_finder_by_shifted_heads_core #(
    parameter int MAX_LEN   = 1024,
    parameter int MAX_EDITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [9:0]          cfg_data,
    input  logic                req_valid,
    output logic                req_stall,
    input  ifsh_pkg::in_item_t  req,
    output logic                res_valid,
    input  logic                res_stall,
    output ifsh_pkg::out_item_t res
);

    // configuration registers
    ifsh_pkg::cfg_t     cfg_reg, cfg_next;

    // front to queue
    logic               f_push;
    ifsh_pkg::in_item_t f_item;
    logic               q_full;

    // queue to engine
    logic               q_valid;
    logic               q_pop;
    ifsh_pkg::in_item_t q_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ifsh_pkg::CFG_MIN_RUN:   cfg_next.min_run        = cfg_data[3:0];
                ifsh_pkg::CFG_MAX_SHIFT: cfg_next.max_shift      = cfg_data;
                ifsh_pkg::CFG_VERIFY:    cfg_next.verify_percent = cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_run        <= 4'd3;
            cfg_reg.max_shift      <= 10'd200;
            cfg_reg.verify_percent <= 7'd60;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accepts and classifies requests
    ifsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_push    (f_push),
        .q_item    (f_item),
        .q_full    (q_full)
    );

    // short queue decouples front and engine
    ifsh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_item (f_item),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .item      (q_item)
    );

    // engine: stores, aligner and result register
    ifsh_engine #(
        .MAX_LEN   (MAX_LEN),
        .MAX_EDITS (MAX_EDITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

FILE: hw/rtl/ifsh_front.sv
// front stage: takes requests, drops unused commands, feeds the queue
// depends on ifsh_pkg
module ifsh_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  ifsh_pkg::in_item_t req,
    output logic               q_push,
    output ifsh_pkg::in_item_t q_item,
    input  logic               q_full
);

    logic               f_valid_reg, f_valid_next;
    ifsh_pkg::in_item_t f_item_reg, f_item_next;
    logic               accept;

    assign req_stall = f_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign q_push    = f_valid_reg && !q_full;
    assign q_item    = f_item_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        f_item_next  = f_item_reg;
        if (accept)
        begin
            // unused command code is taken and dropped here
            f_valid_next = (req.cmd != ifsh_pkg::CMD_NONE);
            f_item_next  = req;
        end
        else if (q_push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg <= f_item_next;
    end

endmodule

FILE: hw/rtl/ifsh_queue.sv
// two-entry queue between front and engine
// depends on ifsh_pkg
module ifsh_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ifsh_pkg::in_item_t push_item,
    output logic               full,
    output logic               valid,
    input  logic               pop,
    output ifsh_pkg::in_item_t item
);

    ifsh_pkg::in_item_t slot_reg [2];
    logic               wp_reg, wp_next;
    logic               rp_reg, rp_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign item    = slot_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wp_next  = do_push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/ifsh_engine.sv
// back end: residue stores, scan sequencer and result register
// depends on ifsh_pkg
module ifsh_engine #(
    parameter int MAX_LEN   = 1024,
    parameter int MAX_EDITS = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  ifsh_pkg::in_item_t  q_item,
    input  ifsh_pkg::cfg_t      cfg,
    output logic                res_valid,
    input  logic                res_stall,
    output ifsh_pkg::out_item_t res
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int EW = $clog2(MAX_EDITS + 1);
    localparam int MW = LW + 7;

    logic [7:0] master_mem [MAX_LEN];
    logic [7:0] query_mem  [MAX_LEN];
    logic [7:0] mrd_reg, qrd_reg;

    ifsh_pkg::eng_state_t st_reg, st_next;
    ifsh_pkg::call_t      call_reg, call_next;

    logic [AW-1:0] abase_reg, abase_next, bbase_reg, bbase_next;
    logic [LW-1:0] n_reg, n_next, i_reg, i_next;
    logic [LW-1:0] exact_reg, exact_next, run_reg, run_next;
    logic [LW-1:0] end_reg, end_next, exend_reg, exend_next;
    logic          open_reg, open_next;
    logic [LW-1:0] cmn_reg, cmn_next, nx_reg, nx_next;
    logic          nxsel_reg, nxsel_next;
    logic [LW-1:0] mlen_reg, mlen_next, qlen_reg, qlen_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] mo_reg, mo_next, qo_reg, qo_next;
    logic [LW-1:0] common_reg, common_next;
    logic [LW-1:0] th_reg, th_next, tc_reg, tc_next;
    logic [9:0]    s_reg, s_next, dels_reg, dels_next, ins_reg, ins_next;
    logic [EW-1:0] nrec_reg, nrec_next;
    logic          trunc_reg, trunc_next;
    logic [LW-1:0] thr_reg, thr_next;
    logic [MW-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic          ver_reg, ver_next;
    ifsh_pkg::out_item_t out_reg, out_next, pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;

    logic          slot_free;
    logic          m_we;
    logic [AW-1:0] ra, rb;
    logic [LW-1:0] ml, ql, hv, hits;
    logic [LW+1:0] ex3;
    logic          ok, eq;
    logic          start;
    logic [AW-1:0] st_abase, st_bbase;
    logic [LW-1:0] st_n;
    ifsh_pkg::call_t st_call;
    logic [10:0]   cmn_sat;

    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign slot_free = !out_valid_reg || !res_stall;
    assign ra        = abase_reg + i_reg[AW-1:0];
    assign rb        = bbase_reg + i_reg[AW-1:0];
    assign ml        = mlen_reg - mo_reg;
    assign ql        = qlen_reg - qo_reg;
    assign ex3       = {2'b00, exend_reg} + {1'b0, exend_reg, 1'b0};
    assign hv        = (ex3 > {2'b00, end_reg}) ? end_reg : '0;
    assign hits      = (ex3 > {2'b00, end_reg}) ? exend_reg : '0;
    assign eq        = (mrd_reg == qrd_reg);
    assign ok        = eq || mrd_reg == ifsh_pkg::CH_UNKNOWN || qrd_reg == ifsh_pkg::CH_UNKNOWN;
    assign cmn_sat   = (32'(common_reg) > 32'd2047) ? 11'h7FF : 11'(common_reg);
    assign q_pop     = (st_reg == ifsh_pkg::E_IDLE) && q_valid;
    assign m_we      = q_pop && (q_item.cmd == ifsh_pkg::CMD_MASTER) &&
                       (32'(mlen_reg) < 32'(MAX_LEN));

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            master_mem[mlen_reg[AW-1:0]] <= q_item.residue;
        end
        mrd_reg <= master_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (q_item.cmd == ifsh_pkg::CMD_QUERY) && (32'(qlen_reg) < 32'(MAX_LEN)))
        begin
            query_mem[qlen_reg[AW-1:0]] <= q_item.residue;
        end
        qrd_reg <= query_mem[rb];
    end

    always_comb
    begin
        st_next = st_reg;       call_next = call_reg;
        abase_next = abase_reg; bbase_next = bbase_reg;
        n_next = n_reg;         i_next = i_reg;
        exact_next = exact_reg; run_next = run_reg;
        end_next = end_reg;     exend_next = exend_reg;
        open_next = open_reg;   cmn_next = cmn_reg;
        nx_next = nx_reg;       nxsel_next = nxsel_reg;
        mlen_next = mlen_reg;   qlen_next = qlen_reg;
        ovf_next = ovf_reg;     mo_next = mo_reg;
        qo_next = qo_reg;       common_next = common_reg;
        th_next = th_reg;       tc_next = tc_reg;
        s_next = s_reg;         dels_next = dels_reg;
        ins_next = ins_reg;     nrec_next = nrec_reg;
        trunc_next = trunc_reg; thr_next = thr_reg;
        lhs_next = lhs_reg;     rhs_next = rhs_reg;
        ver_next = ver_reg;     out_next = out_reg;
        pend_next = pend_reg;
        out_valid_next = out_valid_reg && res_stall;
        start = 1'b0;
        st_abase = '0; st_bbase = '0; st_n = '0;
        st_call = ifsh_pkg::CALL_INIT;

        case (st_reg)
            ifsh_pkg::E_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.cmd)
                        ifsh_pkg::CMD_MASTER:
                        begin
                            if (32'(mlen_reg) < 32'(MAX_LEN)) mlen_next = mlen_reg + 1'b1;
                            else ovf_next = 1'b1;
                        end
                        ifsh_pkg::CMD_QUERY:
                        begin
                            if (32'(qlen_reg) < 32'(MAX_LEN)) qlen_next = qlen_reg + 1'b1;
                            else ovf_next = 1'b1;
                        end
                        ifsh_pkg::CMD_RUN:
                        begin
                            start = 1'b1;
                            st_n  = (mlen_reg < qlen_reg) ? mlen_reg : qlen_reg;
                            st_call = ifsh_pkg::CALL_INIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ifsh_pkg::E_RD:
            begin
                if (i_reg == n_reg)
                begin
                    // end of string closes the last chunk
                    if (open_reg && run_reg >= LW'(cfg.min_run))
                    begin
                        end_next   = n_reg;
                        exend_next = exact_reg;
                    end
                    st_next = ifsh_pkg::E_POST;
                end
                else
                begin
                    st_next = ifsh_pkg::E_PR;
                end
            end
            ifsh_pkg::E_PR:
            begin
                if (ok)
                begin
                    if (eq)
                    begin
                        exact_next = exact_reg + 1'b1;
                        run_next   = run_reg + 1'b1;
                    end
                    open_next = 1'b1;
                end
                else
                begin
                    if (open_reg && run_reg >= LW'(cfg.min_run))
                    begin
                        end_next   = i_reg;
                        exend_next = exact_reg;
                    end
                    open_next = 1'b0;
                    run_next  = '0;
                end
                if (eq && mrd_reg != ifsh_pkg::CH_UNKNOWN && mrd_reg != ifsh_pkg::CH_GAP)
                    cmn_next = cmn_reg + 1'b1;
                if (nxsel_reg ? (mrd_reg != ifsh_pkg::CH_UNKNOWN)
                              : (qrd_reg != ifsh_pkg::CH_UNKNOWN))
                    nx_next = nx_reg + 1'b1;
                i_next  = i_reg + 1'b1;
                st_next = ifsh_pkg::E_RD;
            end
            ifsh_pkg::E_POST:
            begin
                case (call_reg)
                    ifsh_pkg::CALL_INIT:
                    begin
                        mo_next = hv; qo_next = hv; common_next = hits;
                        st_next = ifsh_pkg::E_LOOP;
                    end
                    ifsh_pkg::CALL_DEL:
                    begin
                        th_next = hv; tc_next = hits;
                        if (hv > LW'(cfg.min_run))
                        begin
                            dels_next = s_reg;
                            st_next   = ifsh_pkg::E_DECIDE;
                        end
                        else st_next = ifsh_pkg::E_INSTRY;
                    end
                    ifsh_pkg::CALL_INS:
                    begin
                        th_next = hv; tc_next = hits;
                        if (hv > LW'(cfg.min_run))
                        begin
                            ins_next = s_reg;
                            st_next  = ifsh_pkg::E_DECIDE;
                        end
                        else
                        begin
                            s_next  = s_reg + 1'b1;
                            st_next = ifsh_pkg::E_SHIFT;
                        end
                    end
                    ifsh_pkg::CALL_PLAIN:
                    begin
                        common_next = common_reg + cmn_reg;
                        st_next     = ifsh_pkg::E_NONX;
                    end
                    default:
                    begin
                        thr_next = nx_reg;
                        st_next  = ifsh_pkg::E_CMP;
                    end
                endcase
            end
            ifsh_pkg::E_LOOP:
            begin
                if (mo_reg < mlen_reg && qo_reg < qlen_reg)
                begin
                    s_next = 10'd1; th_next = '0; tc_next = '0;
                    dels_next = '0; ins_next = '0;
                    st_next = ifsh_pkg::E_SHIFT;
                end
                else st_next = ifsh_pkg::E_NONX;
            end
            ifsh_pkg::E_SHIFT:
            begin
                if (s_reg >= cfg.max_shift) st_next = ifsh_pkg::E_DECIDE;
                else if (32'(s_reg) < 32'(ml))
                begin
                    // deletion: master skips s residues
                    start    = 1'b1;
                    st_abase = AW'(mo_reg + LW'(s_reg));
                    st_bbase = AW'(qo_reg);
                    st_n     = ((ml - LW'(s_reg)) < ql) ? (ml - LW'(s_reg)) : ql;
                    st_call  = ifsh_pkg::CALL_DEL;
                end
                else st_next = ifsh_pkg::E_INSTRY;
            end
            ifsh_pkg::E_INSTRY:
            begin
                if (32'(s_reg) < 32'(ql))
                begin
                    // insertion: query skips s residues
                    start    = 1'b1;
                    st_abase = AW'(mo_reg);
                    st_bbase = AW'(qo_reg + LW'(s_reg));
                    st_n     = (ml < (ql - LW'(s_reg))) ? ml : (ql - LW'(s_reg));
                    st_call  = ifsh_pkg::CALL_INS;
                end
                else
                begin
                    s_next  = s_reg + 1'b1;
                    st_next = ifsh_pkg::E_SHIFT;
                end
            end
            ifsh_pkg::E_DECIDE:
            begin
                if (th_reg == '0)
                begin
                    // no head: count common residues of the tails and stop
                    start    = 1'b1;
                    st_abase = AW'(mo_reg);
                    st_bbase = AW'(qo_reg);
                    st_n     = (ml < ql) ? ml : ql;
                    st_call  = ifsh_pkg::CALL_PLAIN;
                end
                else
                begin
                    st_next = ifsh_pkg::E_LOOP;
                    if (dels_reg != '0 || ins_reg != '0)
                    begin
                        if (32'(nrec_reg) < 32'(MAX_EDITS))
                        begin
                            pend_next = '0;
                            pend_next.record_kind = (dels_reg != '0) ?
                                ifsh_pkg::KIND_DEL : ifsh_pkg::KIND_INS;
                            pend_next.position = (dels_reg != '0) ? 11'(qo_reg) : 11'(mo_reg);
                            pend_next.shift_count = (dels_reg != '0) ? dels_reg : ins_reg;
                            nrec_next = nrec_reg + 1'b1;
                            st_next   = ifsh_pkg::E_EMIT;
                        end
                        else trunc_next = 1'b1;
                    end
                    // short head with no record still advances both strings
                    if (dels_reg != '0)
                    begin
                        mo_next = mo_reg + th_reg + LW'(dels_reg);
                        qo_next = qo_reg + th_reg;
                    end
                    else
                    begin
                        qo_next = qo_reg + th_reg + LW'(ins_reg);
                        mo_next = mo_reg + th_reg;
                    end
                    common_next = common_reg + tc_reg;
                end
            end
            ifsh_pkg::E_EMIT:
            begin
                if (slot_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    st_next        = ifsh_pkg::E_LOOP;
                end
            end
            ifsh_pkg::E_NONX:
            begin
                start    = 1'b1;
                st_n     = (mlen_reg < qlen_reg) ? mlen_reg : qlen_reg;
                st_call  = ifsh_pkg::CALL_NONX;
            end
            ifsh_pkg::E_CMP:
            begin
                lhs_next = MW'(common_reg) * MW'(100);
                rhs_next = MW'(thr_reg) * MW'(cfg.verify_percent);
                st_next  = ifsh_pkg::E_VER;
            end
            ifsh_pkg::E_VER:
            begin
                ver_next = (lhs_reg >= rhs_reg);
                st_next  = ifsh_pkg::E_SUM;
            end
            ifsh_pkg::E_SUM:
            begin
                if (slot_free)
                begin
                    out_next              = '0;
                    out_next.record_kind  = ifsh_pkg::KIND_SUMMARY;
                    out_next.common_total = cmn_sat;
                    out_next.verified     = ver_reg;
                    out_next.overflowed   = ovf_reg;
                    out_next.truncated    = trunc_reg;
                    out_next.last         = 1'b1;
                    out_valid_next        = 1'b1;
                    mlen_next  = '0;
                    qlen_next  = '0;
                    ovf_next   = 1'b0;
                    nrec_next  = '0;
                    trunc_next = 1'b0;
                    st_next    = ifsh_pkg::E_IDLE;
                end
            end
            default:
            begin
                st_next = ifsh_pkg::E_IDLE;
            end
        endcase

        if (start)
        begin
            abase_next = st_abase;
            bbase_next = st_bbase;
            n_next     = st_n;
            call_next  = st_call;
            nxsel_next = (mlen_reg < qlen_reg);
            i_next = '0; exact_next = '0; run_next = '0; end_next = '0;
            exend_next = '0; open_next = 1'b0; cmn_next = '0; nx_next = '0;
            st_next = ifsh_pkg::E_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ifsh_pkg::E_IDLE;
            mlen_reg      <= '0;
            qlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            nrec_reg      <= '0;
            trunc_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            mlen_reg      <= mlen_next;
            qlen_reg      <= qlen_next;
            ovf_reg       <= ovf_next;
            nrec_reg      <= nrec_next;
            trunc_reg     <= trunc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        call_reg <= call_next;   abase_reg <= abase_next; bbase_reg <= bbase_next;
        n_reg <= n_next;         i_reg <= i_next;         exact_reg <= exact_next;
        run_reg <= run_next;     end_reg <= end_next;     exend_reg <= exend_next;
        open_reg <= open_next;   cmn_reg <= cmn_next;     nx_reg <= nx_next;
        nxsel_reg <= nxsel_next; mo_reg <= mo_next;       qo_reg <= qo_next;
        common_reg <= common_next; th_reg <= th_next;     tc_reg <= tc_next;
        s_reg <= s_next;         dels_reg <= dels_next;   ins_reg <= ins_next;
        thr_reg <= thr_next;     lhs_reg <= lhs_next;     rhs_reg <= rhs_next;
        ver_reg <= ver_next;     out_reg <= out_next;     pend_reg <= pend_next;
    end

endmodule

FILE: tb/sv/tb_indel_finder_by_shifted_heads_core.sv
// testbench for indel_finder_by_shifted_heads_core: directed table, store-full and edit-cap cases, then random runs
// checks every record against a local predictor of the greedy shifted-head alignment or a hand-typed record
// depends on ifsh_pkg and indel_finder_by_shifted_heads_core
module tb_indel_finder_by_shifted_heads_core;

    localparam int MEM_DEPTH = 1024;
    localparam int EDIT_CAP  = 63;
    localparam int SETTLE    = 40;

    typedef struct {
        ifsh_pkg::cmd_t      cmd;
        logic [7:0]          residue;
        bit                  fixed;
        ifsh_pkg::out_item_t want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [9:0]          cfg_data;
    logic                req_valid;
    logic                req_stall;
    ifsh_pkg::in_item_t  req;
    logic                res_valid;
    logic                res_stall;
    ifsh_pkg::out_item_t res;

    // request queue toward the block and records still owed by it
    stim_row_t           request_q[$];
    stim_row_t           in_flight;
    ifsh_pkg::out_item_t record_q[$];
    int                  errors = 0;
    bit                  hold_req = 1'b0;

    // predictor state
    logic [7:0]  master_mem [MEM_DEPTH];
    logic [7:0]  query_mem  [MEM_DEPTH];
    int unsigned master_len = 0;
    int unsigned query_len = 0;
    bit          dropped = 1'b0;
    int unsigned run_min;
    int unsigned shift_lim;
    int unsigned pct_need;

    // directed table: expected record typed in only where it is obvious
    stim_row_t dir_tab [] = '{
        // empty strings right after reset: nothing common, trivially verified
        '{ifsh_pkg::CMD_RUN,    8'h00, 1'b1,
          '{ifsh_pkg::KIND_SUMMARY, 11'd0, 10'd0, 11'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ifsh_pkg::CMD_NONE,   8'hFF, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'h58, 1'b0, '0},
        // master only: query is the shorter side and has no residues
        '{ifsh_pkg::CMD_RUN,    8'h00, 1'b1,
          '{ifsh_pkg::KIND_SUMMARY, 11'd0, 10'd0, 11'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{ifsh_pkg::CMD_QUERY,  8'h41, 1'b0, '0},
        '{ifsh_pkg::CMD_RUN,    8'hFF, 1'b1,
          '{ifsh_pkg::KIND_SUMMARY, 11'd0, 10'd0, 11'd0, 1'b1, 1'b0, 1'b0, 1'b1}},
        // extreme bytes and gap on both sides, unknown on the master side
        '{ifsh_pkg::CMD_MASTER, 8'h00, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'hFF, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'h2D, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'h58, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'h41, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'h43, 1'b0, '0},
        '{ifsh_pkg::CMD_MASTER, 8'h44, 1'b0, '0},
        '{ifsh_pkg::CMD_QUERY,  8'h00, 1'b0, '0},
        '{ifsh_pkg::CMD_QUERY,  8'hFF, 1'b0, '0},
        '{ifsh_pkg::CMD_QUERY,  8'h2D, 1'b0, '0},
        '{ifsh_pkg::CMD_QUERY,  8'h41, 1'b0, '0},
        '{ifsh_pkg::CMD_QUERY,  8'h41, 1'b0, '0},
        '{ifsh_pkg::CMD_QUERY,  8'h43, 1'b0, '0},
        '{ifsh_pkg::CMD_NONE,   8'h00, 1'b0, '0},
        '{ifsh_pkg::CMD_RUN,    8'h00, 1'b0, '0}
    };

    indel_finder_by_shifted_heads_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #60_000_000;
        $display("FAIL indel_finder_by_shifted_heads_core");
        $finish;
    end

    // prefix ending at the last compatible chunk with enough exact matches
    function automatic int unsigned head_len(int unsigned mo, int unsigned ml,
                                             int unsigned qo, int unsigned ql,
                                             output int unsigned hits);
        int unsigned n;
        int unsigned exact;
        int unsigned streak;
        int unsigned stop;
        int unsigned exact_stop;
        bit          open;
        bit          ok;
        logic [7:0]  x;
        logic [7:0]  y;
        n = (ml < ql) ? ml : ql;
        exact = 0;
        streak = 0;
        stop = 0;
        exact_stop = 0;
        open = 1'b0;
        for (int unsigned i = 0; i <= n; i++)
        begin
            ok = 1'b0;
            if (i < n)
            begin
                x = master_mem[mo + i];
                y = query_mem[qo + i];
                ok = (x == y) || (x == ifsh_pkg::CH_UNKNOWN) || (y == ifsh_pkg::CH_UNKNOWN);
                if (ok)
                begin
                    if (x == y)
                    begin
                        exact++;
                        streak++;
                    end
                    open = 1'b1;
                end
            end
            if (!ok)
            begin
                if (open && streak >= run_min)
                begin
                    stop = i;
                    exact_stop = exact;
                end
                open = 1'b0;
                streak = 0;
            end
        end
        if (exact_stop * 3 > stop)
        begin
            hits = exact_stop;
            return stop;
        end
        hits = 0;
        return 0;
    endfunction

    function automatic int unsigned tail_common(int unsigned mo, int unsigned ml,
                                                int unsigned qo, int unsigned ql);
        int unsigned n;
        int unsigned c;
        n = (ml < ql) ? ml : ql;
        c = 0;
        for (int unsigned i = 0; i < n; i++)
            if (master_mem[mo + i] == query_mem[qo + i]
                && master_mem[mo + i] != ifsh_pkg::CH_UNKNOWN
                && master_mem[mo + i] != ifsh_pkg::CH_GAP)
                c++;
        return c;
    endfunction

    function automatic ifsh_pkg::out_item_t edit_rec(ifsh_pkg::kind_t kind, int unsigned pos,
                                                      int unsigned cnt);
        ifsh_pkg::out_item_t r;
        r = '0;
        r.record_kind = kind;
        r.position = pos[10:0];
        r.shift_count = cnt[9:0];
        return r;
    endfunction

    // greedy alignment of both stores; queues edit records and the summary
    task automatic align_and_report();
        int unsigned         mo;
        int unsigned         qo;
        int unsigned         ml;
        int unsigned         ql;
        int unsigned         hits;
        int unsigned         common;
        int unsigned         th;
        int unsigned         tc;
        int unsigned         dels;
        int unsigned         ins;
        int unsigned         nonx;
        int                  nrec;
        bit                  trunc;
        ifsh_pkg::out_item_t sum;
        nrec = 0;
        trunc = 1'b0;
        mo = head_len(0, master_len, 0, query_len, hits);
        qo = mo;
        common = hits;
        while (mo < master_len && qo < query_len)
        begin
            ml = master_len - mo;
            ql = query_len - qo;
            dels = 0;
            ins = 0;
            th = 0;
            tc = 0;
            // deletion tried before insertion at every shift
            for (int unsigned s = 1; s < shift_lim; s++)
            begin
                if (s < ml)
                begin
                    th = head_len(mo + s, ml - s, qo, ql, tc);
                    if (th > run_min)
                    begin
                        dels = s;
                        break;
                    end
                end
                if (s < ql)
                begin
                    th = head_len(mo, ml, qo + s, ql - s, tc);
                    if (th > run_min)
                    begin
                        ins = s;
                        break;
                    end
                end
            end
            // no head anywhere: count the tails and stop
            if (th == 0)
            begin
                common += tail_common(mo, ml, qo, ql);
                break;
            end
            if (dels != 0)
            begin
                if (nrec < EDIT_CAP)
                begin
                    record_q.insert(record_q.size(), edit_rec(ifsh_pkg::KIND_DEL, qo, dels));
                    nrec++;
                end
                else
                    trunc = 1'b1;
                mo += th + dels;
                qo += th;
            end
            else
            begin
                // a short head with no shift found still advances, silently
                if (ins != 0)
                begin
                    if (nrec < EDIT_CAP)
                    begin
                        record_q.insert(record_q.size(),
                                        edit_rec(ifsh_pkg::KIND_INS, mo, ins));
                        nrec++;
                    end
                    else
                        trunc = 1'b1;
                end
                qo += th + ins;
                mo += th;
            end
            common += tc;
        end
        // non-X residues of the shorter string set the bar
        nonx = 0;
        if (master_len < query_len)
        begin
            for (int unsigned i = 0; i < master_len; i++)
                if (master_mem[i] != ifsh_pkg::CH_UNKNOWN)
                    nonx++;
        end
        else
        begin
            for (int unsigned i = 0; i < query_len; i++)
                if (query_mem[i] != ifsh_pkg::CH_UNKNOWN)
                    nonx++;
        end
        sum = '0;
        sum.record_kind = ifsh_pkg::KIND_SUMMARY;
        sum.common_total = (common > 2047) ? 11'd2047 : common[10:0];
        sum.verified = (longint'(common) * 100 >= longint'(nonx) * pct_need);
        sum.overflowed = dropped;
        sum.truncated = trunc;
        sum.last = 1'b1;
        record_q.insert(record_q.size(), sum);
        master_len = 0;
        query_len = 0;
        dropped = 1'b0;
    endtask

    // update the predictor for one accepted request
    task automatic take_request(stim_row_t r);
        case (r.cmd)
            ifsh_pkg::CMD_MASTER:
            begin
                if (master_len < MEM_DEPTH)
                begin
                    master_mem[master_len] = r.residue;
                    master_len++;
                end
                else
                    dropped = 1'b1;
            end
            ifsh_pkg::CMD_QUERY:
            begin
                if (query_len < MEM_DEPTH)
                begin
                    query_mem[query_len] = r.residue;
                    query_len++;
                end
                else
                    dropped = 1'b1;
            end
            ifsh_pkg::CMD_RUN:
            begin
                align_and_report();
                // hand-typed record replaces the predicted single summary
                if (r.fixed)
                begin
                    void'(record_q.pop_back());
                    record_q.insert(record_q.size(), r.want);
                end
            end
            default: ;
        endcase
    endtask

    // sender: bursts of random length with random gaps
    initial
    begin
        int burst_left;
        int gap_left;
        req_valid = 1'b0;
        req = '0;
        burst_left = 0;
        gap_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (req_valid && !req_stall)
                take_request(in_flight);
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    in_flight = request_q.pop_front();
                    req <= '{cmd: in_flight.cmd, residue: in_flight.residue};
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern drawn anew from four modes, plus one long hold-off
    // that starts once records are coming, so the block backs up into its input
    initial
    begin
        int mode;
        int hold_left;
        int tick;
        bit held;
        res_stall = 1'b0;
        mode = 0;
        hold_left = 0;
        tick = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_req && !held && res_valid)
            begin
                held = 1'b1;
                hold_left = 800;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            case (mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 99) < 30);
                2: res_stall <= tick[0];
                default: res_stall <= ($urandom_range(0, 99) < 80);
            endcase
        end
    end

    // record checker
    initial
    begin
        ifsh_pkg::out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (record_q.size() == 0)
                begin
                    $display("%0t: unexpected record %h", $time, res);
                    errors++;
                end
                else
                begin
                    want = record_q.pop_front();
                    if (res.record_kind !== want.record_kind)
                    begin
                        $display("%0t: record_kind exp %0d got %0d", $time,
                                 want.record_kind, res.record_kind);
                        errors++;
                    end
                    if (res.position !== want.position)
                    begin
                        $display("%0t: position exp %0d got %0d", $time,
                                 want.position, res.position);
                        errors++;
                    end
                    if (res.shift_count !== want.shift_count)
                    begin
                        $display("%0t: shift_count exp %0d got %0d", $time,
                                 want.shift_count, res.shift_count);
                        errors++;
                    end
                    if (res.common_total !== want.common_total)
                    begin
                        $display("%0t: common_total exp %0d got %0d", $time,
                                 want.common_total, res.common_total);
                        errors++;
                    end
                    if (res.verified !== want.verified)
                    begin
                        $display("%0t: verified exp %0b got %0b", $time,
                                 want.verified, res.verified);
                        errors++;
                    end
                    if (res.overflowed !== want.overflowed)
                    begin
                        $display("%0t: overflowed exp %0b got %0b", $time,
                                 want.overflowed, res.overflowed);
                        errors++;
                    end
                    if (res.truncated !== want.truncated)
                    begin
                        $display("%0t: truncated exp %0b got %0b", $time,
                                 want.truncated, res.truncated);
                        errors++;
                    end
                    if (res.last !== want.last)
                    begin
                        $display("%0t: last exp %0b got %0b", $time, want.last, res.last);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_req(ifsh_pkg::cmd_t cmd, logic [7:0] residue);
        request_q.insert(request_q.size(), '{cmd: cmd, residue: residue, fixed: 1'b0, want: '0});
    endtask

    // wait until all requests are taken and every record has come back
    task automatic wait_drained();
        @(negedge clk);
        while (request_q.size() != 0 || req_valid || record_q.size() != 0)
            @(negedge clk);
        // a trailing load makes no record, give the block time to settle
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(ifsh_pkg::cfg_index_t idx, logic [9:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ifsh_pkg::CFG_MIN_RUN:   run_min = value[3:0];
            ifsh_pkg::CFG_MAX_SHIFT: shift_lim = value;
            default:                 pct_need = value[6:0];
        endcase
    endtask

    task automatic set_config(int unsigned mr, int unsigned ms, int unsigned vp);
        wait_drained();
        write_reg(ifsh_pkg::CFG_MIN_RUN, mr[9:0]);
        write_reg(ifsh_pkg::CFG_MAX_SHIFT, ms[9:0]);
        write_reg(ifsh_pkg::CFG_VERIFY, vp[9:0]);
    endtask

    function automatic logic [7:0] pick_residue();
        string alpha;
        int    p;
        alpha = "ACDEFGHIKLMNPQRSTVWY";
        p = $urandom_range(0, 99);
        if (p < 80)
            return alpha[$urandom_range(0, 19)];
        if (p < 88)
            return ifsh_pkg::CH_UNKNOWN;
        if (p < 93)
            return ifsh_pkg::CH_GAP;
        return 8'($urandom_range(0, 255));
    endfunction

    // a master string and a mutated copy as query, with a little noise
    task automatic queue_run(int max_len);
        logic [7:0] base [$];
        logic [7:0] mut  [$];
        int         n;
        int         p;
        n = $urandom_range(0, max_len);
        for (int i = 0; i < n; i++)
            base.insert(base.size(), pick_residue());
        if ($urandom_range(0, 9) == 0)
        begin
            // unrelated query
            for (int i = 0; i < $urandom_range(0, max_len); i++)
                mut.insert(mut.size(), pick_residue());
        end
        else
        foreach (base[i])
        begin
            p = $urandom_range(0, 99);
            if (p < 4)
                continue;
            if (p < 8)
                mut.insert(mut.size(), pick_residue());
            if (p >= 8 && p < 12)
                mut.insert(mut.size(), pick_residue());
            else if (p >= 12 && p < 15)
                mut.insert(mut.size(), ifsh_pkg::CH_UNKNOWN);
            else
                mut.insert(mut.size(), base[i]);
        end
        foreach (base[i])
        begin
            push_req(ifsh_pkg::CMD_MASTER, base[i]);
            if ($urandom_range(0, 19) == 0)
                push_req(ifsh_pkg::CMD_NONE, 8'($urandom_range(0, 255)));
        end
        foreach (mut[i])
            push_req(ifsh_pkg::CMD_QUERY, mut[i]);
        push_req(ifsh_pkg::CMD_RUN, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        string block;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ifsh_pkg::CFG_MIN_RUN;
        cfg_data = '0;
        run_min = 3;
        shift_lim = 200;
        pct_need = 60;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings
        foreach (dir_tab[i])
            request_q.insert(request_q.size(), dir_tab[i]);
        wait_drained();

        // store full on both sides: the extra residue is dropped
        for (int i = 0; i < MEM_DEPTH + 1; i++)
        begin
            push_req(ifsh_pkg::CMD_MASTER, 8'h41);
            push_req(ifsh_pkg::CMD_QUERY, 8'h41);
        end
        request_q.insert(request_q.size(), '{cmd: ifsh_pkg::CMD_RUN, residue: 8'h00, fixed: 1'b1,
            want: '{ifsh_pkg::KIND_SUMMARY, 11'd0, 10'd0, 11'd1024, 1'b1, 1'b1, 1'b0, 1'b1}});
        wait_drained();

        // more deletions than records allowed, receiver held off meanwhile
        block = "ACDEFGHIKL";
        for (int b = 0; b < 70; b++)
        begin
            for (int i = 0; i < 10; i++)
            begin
                push_req(ifsh_pkg::CMD_MASTER, block[i]);
                push_req(ifsh_pkg::CMD_QUERY, block[i]);
            end
            push_req(ifsh_pkg::CMD_MASTER, 8'h57);
        end
        push_req(ifsh_pkg::CMD_RUN, 8'h00);
        queue_run(30);
        queue_run(30);
        hold_req = 1'b1;
        wait_drained();

        // random phases, extremes of the registers first
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_config(1, 1, 0);
                1: set_config(15, 1023, 100);
                2: set_config(1, 1023, 100);
                3: set_config(3, 200, 60);
                default: set_config($urandom_range(1, 15),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(1, 40),
                    $urandom_range(0, 100));
            endcase
            for (int r = 0; r < 2; r++)
                queue_run(($urandom_range(0, 7) == 0) ? 120 : 30);
        end
        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS indel_finder_by_shifted_heads_core");
        else
            $display("FAIL indel_finder_by_shifted_heads_core");
        $finish;
    end

endmodule

FILE: indel_finder_by_shifted_heads_core.f
hw/rtl/ifsh_pkg.sv
hw/rtl/ifsh_front.sv
hw/rtl/ifsh_queue.sv
hw/rtl/ifsh_engine.sv
hw/rtl/indel_finder_by_shifted_heads_core.sv
tb/sv/tb_indel_finder_by_shifted_heads_core.sv
